// ===== rtl/core/can_rx_frame_cache_diag_latch_assert.svh =====
// Assertion macros for the CAN receive frame cache.
// Included by the top level; needs nothing else.
`ifndef CAN_RX_FRAME_CACHE_DIAG_LATCH_ASSERT_SVH
`define CAN_RX_FRAME_CACHE_DIAG_LATCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRFC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("crfc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CRFC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("crfc: next-cycle check failed");

`endif

// ===== rtl/core/crfc_pkg.sv =====
// Shared types and constants for the CAN receive frame cache.
// Used by every module of the block; depends on nothing.
package crfc_pkg;

    // Field widths.
    localparam int unsigned IdW      = 11;
    localparam int unsigned LenW     = 4;
    localparam int unsigned DataW    = 64;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned PidW     = 8;
    localparam int unsigned ValW     = 16;
    localparam int unsigned NumSlots = 5;
    localparam int unsigned SlotIdxW = 3;
    localparam int unsigned CfgIdxW  = 3;

    // Stream widths; the tdata widths are padded to whole bytes.
    localparam int unsigned STdataW = 152;
    localparam int unsigned MTdataW = 152;
    localparam int unsigned STuserW = 3;

    // Reset values of the identifier registers.
    localparam logic [IdW-1:0] RstRpmId     = 11'h100;
    localparam logic [IdW-1:0] RstSpeedId   = 11'h110;
    localparam logic [IdW-1:0] RstCoolantId = 11'h120;
    localparam logic [IdW-1:0] RstGearId    = 11'h121;
    localparam logic [IdW-1:0] RstFuelId    = 11'h32F;
    localparam logic [IdW-1:0] RstDiagId    = 11'h746;

    // Diagnostic reply bytes.
    localparam logic [7:0] SessMinByte0 = 8'h02;
    localparam logic [7:0] SessByte1    = 8'h50;
    localparam logic [7:0] SessByte2    = 8'h80;
    localparam logic [7:0] ReadByte1    = 8'h61;
    localparam logic [LenW-1:0] SessMinLen = 4'd3;
    localparam logic [LenW-1:0] ReadMinLen = 4'd5;
    localparam logic [LenW-1:0] MaxLen     = 4'd8;

    // Item kinds carried in tuser.
    typedef enum logic [2:0] {
        MODE_FRAME     = 3'd0,
        MODE_SESS_REQ  = 3'd1,
        MODE_READ_REQ  = 3'd2,
        MODE_TAKE_SESS = 3'd3,
        MODE_TAKE_READ = 3'd4,
        MODE_GET_SLOT  = 3'd5
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        REG_RPM_ID     = 3'd0,
        REG_SPEED_ID   = 3'd1,
        REG_COOLANT_ID = 3'd2,
        REG_GEAR_ID    = 3'd3,
        REG_FUEL_ID    = 3'd4,
        REG_DIAG_ID    = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } state_t;

    // Result of an identifier lookup against the slot table.
    typedef struct packed {
        logic                hit;
        logic [SlotIdxW-1:0] idx;
    } match_t;

    // One cache entry as held in the slot memory.
    typedef struct packed {
        logic [LenW-1:0]  len;
        logic [DataW-1:0] payload;
        logic [TimeW-1:0] stamp;
    } slot_entry_t;

endpackage

// ===== rtl/core/crfc_id_match.sv =====
// Priority identifier matcher against the five slot identifiers.
// Depends on crfc_pkg.
module crfc_id_match (
    input  logic [crfc_pkg::NumSlots-1:0][crfc_pkg::IdW-1:0] id_list,
    input  logic [crfc_pkg::IdW-1:0]                          key,
    output crfc_pkg::match_t                                  match
);

    // Parallel compares; the lowest-numbered matching slot wins.
    always_comb begin
        match.hit = 1'b0;
        match.idx = '0;
        for (int k = crfc_pkg::NumSlots - 1; k >= 0; k--) begin
            if (id_list[k] == key) begin
                match.hit = 1'b1;
                match.idx = crfc_pkg::SlotIdxW'(k);
            end
        end
    end

endmodule

// ===== rtl/core/crfc_slot_mem.sv =====
// Slot cache memory: one write port, one registered read port, per-entry valid bits.
// Depends on crfc_pkg.
module crfc_slot_mem (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [crfc_pkg::SlotIdxW-1:0]  wr_idx,
    input  crfc_pkg::slot_entry_t          wr_data,
    input  logic                           rd_en,
    input  logic [crfc_pkg::SlotIdxW-1:0]  rd_idx,
    output logic                           rd_valid,
    output crfc_pkg::slot_entry_t          rd_data
);

    crfc_pkg::slot_entry_t slot_mem [crfc_pkg::NumSlots];

    logic [crfc_pkg::NumSlots-1:0] valid_reg, valid_next;
    logic                          rd_valid_reg;
    crfc_pkg::slot_entry_t         rd_data_reg;

    // An entry becomes valid on its first write and stays so until reset.
    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= slot_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (rd_en) begin
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    // An entry never written reads as all zero.
    assign rd_valid = rd_valid_reg;
    assign rd_data  = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/core/can_rx_frame_cache_diag_latch.sv =====
// Top level of the CAN receive frame cache with diagnostic reply latch.
// Depends on crfc_pkg, crfc_id_match, crfc_slot_mem and the assertion header.
//
// Usage: one item per s_ transaction, its kind in s_tuser. A received frame
// updates the receive time and either a cache slot or the diagnostic flags;
// request-sent items clear a flag. These give no result. Take-session,
// take-read and get-slot items each give one m_ transaction. For such an
// item the accept cycle compares identifiers and reads the slot memory; the
// block then stays in its response state, with s_tready low, until the
// output register is free, and loads it there. The output register lets a
// new item be accepted while a result still waits; if the receiver stalls
// and a second result is ready, the block holds it and keeps s_tready low
// until the output register frees. Configuration is a plain write port
// (cfg_wr_en, cfg_index, cfg_data), to be used only while the block is idle;
// the block itself does not enforce this. Indexes past the last register are
// ignored. Reset (aresetn low, synchronous) restores the default identifiers,
// clears all slots, flags and times and empties the output register.
`include "can_rx_frame_cache_diag_latch_assert.svh"

module can_rx_frame_cache_diag_latch (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input item stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata from bit 0: raw_id(29) frame_len(4) frame_data(64) expected_pid(8)
    // lookup_id(11) now_ms(32), zero pad(4).
    input  logic [crfc_pkg::STdataW-1:0]    s_tdata,
    // tuser: mode(3).
    input  logic [crfc_pkg::STuserW-1:0]    s_tuser,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata from bit 0: ok(1) pid_value(16) slot_data(64) slot_len(4)
    // slot_time(32) last_rx_ms(32), zero pad(3).
    output logic [crfc_pkg::MTdataW-1:0]    m_tdata,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [crfc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [crfc_pkg::IdW-1:0]        cfg_data
);

    // Input field unpacking.
    logic [crfc_pkg::IdW-1:0]   in_id;
    logic [crfc_pkg::LenW-1:0]  in_len;
    logic [crfc_pkg::DataW-1:0] in_data;
    logic [crfc_pkg::PidW-1:0]  in_pid;
    logic [crfc_pkg::IdW-1:0]   in_lookup;
    logic [crfc_pkg::TimeW-1:0] in_now;

    assign in_id     = s_tdata[10:0];
    assign in_len    = s_tdata[32:29];
    assign in_data   = s_tdata[96:33];
    assign in_pid    = s_tdata[104:97];
    assign in_lookup = s_tdata[115:105];
    assign in_now    = s_tdata[147:116];

    // Configuration registers.
    logic [crfc_pkg::NumSlots-1:0][crfc_pkg::IdW-1:0] slot_id_reg, slot_id_next;
    logic [crfc_pkg::IdW-1:0]                          diag_id_reg, diag_id_next;

    always_comb begin
        slot_id_next = slot_id_reg;
        diag_id_next = diag_id_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                crfc_pkg::REG_RPM_ID:     slot_id_next[0] = cfg_data;
                crfc_pkg::REG_SPEED_ID:   slot_id_next[1] = cfg_data;
                crfc_pkg::REG_COOLANT_ID: slot_id_next[2] = cfg_data;
                crfc_pkg::REG_GEAR_ID:    slot_id_next[3] = cfg_data;
                crfc_pkg::REG_FUEL_ID:    slot_id_next[4] = cfg_data;
                crfc_pkg::REG_DIAG_ID:    diag_id_next    = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_id_reg[0] <= crfc_pkg::RstRpmId;
            slot_id_reg[1] <= crfc_pkg::RstSpeedId;
            slot_id_reg[2] <= crfc_pkg::RstCoolantId;
            slot_id_reg[3] <= crfc_pkg::RstGearId;
            slot_id_reg[4] <= crfc_pkg::RstFuelId;
            diag_id_reg    <= crfc_pkg::RstDiagId;
        end else begin
            slot_id_reg <= slot_id_next;
            diag_id_reg <= diag_id_next;
        end
    end

    // Identifier lookups for received frames and for slot reads.
    crfc_pkg::match_t rx_match, lk_match;

    crfc_id_match u_rx_match (
        .id_list (slot_id_reg),
        .key     (in_id),
        .match   (rx_match)
    );

    crfc_id_match u_lk_match (
        .id_list (slot_id_reg),
        .key     (in_lookup),
        .match   (lk_match)
    );

    // Handshake and item decode.
    crfc_pkg::state_t state_reg, state_next;
    logic             accept;
    logic             is_frame, is_sess_req, is_read_req;
    logic             is_take_sess, is_take_read, is_get_slot;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        is_frame     = 1'b0;
        is_sess_req  = 1'b0;
        is_read_req  = 1'b0;
        is_take_sess = 1'b0;
        is_take_read = 1'b0;
        is_get_slot  = 1'b0;
        case (s_tuser)
            crfc_pkg::MODE_FRAME:     is_frame     = 1'b1;
            crfc_pkg::MODE_SESS_REQ:  is_sess_req  = 1'b1;
            crfc_pkg::MODE_READ_REQ:  is_read_req  = 1'b1;
            crfc_pkg::MODE_TAKE_SESS: is_take_sess = 1'b1;
            crfc_pkg::MODE_TAKE_READ: is_take_read = 1'b1;
            crfc_pkg::MODE_GET_SLOT:  is_get_slot  = 1'b1;
            default: ;
        endcase
    end

    // Slot entry built from a received frame: length clamped, bytes past it zeroed.
    logic [crfc_pkg::LenW-1:0] clamp_len;
    crfc_pkg::slot_entry_t     new_entry;

    always_comb begin
        clamp_len = (in_len > crfc_pkg::MaxLen) ? crfc_pkg::MaxLen : in_len;
        new_entry.len   = clamp_len;
        new_entry.stamp = in_now;
        for (int b = 0; b < 8; b++) begin
            new_entry.payload[8*b +: 8] =
                (crfc_pkg::LenW'(b) < clamp_len) ? in_data[8*b +: 8] : 8'h00;
        end
    end

    // Slot memory: written by cached frames, read by slot lookups.
    logic                  slot_wr_en;
    logic                  slot_rd_valid;
    crfc_pkg::slot_entry_t slot_rd_data;

    assign slot_wr_en = accept && is_frame && rx_match.hit;

    crfc_slot_mem u_slot_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (slot_wr_en),
        .wr_idx   (rx_match.idx),
        .wr_data  (new_entry),
        .rd_en    (accept && is_get_slot),
        .rd_idx   (lk_match.idx),
        .rd_valid (slot_rd_valid),
        .rd_data  (slot_rd_data)
    );

    // Diagnostic reply decode, on the unclamped length.
    logic diag_hit, sess_reply, read_reply;

    assign diag_hit   = is_frame && !rx_match.hit && (in_id == diag_id_reg);
    assign sess_reply = (in_len >= crfc_pkg::SessMinLen)
                     && (in_data[7:0] >= crfc_pkg::SessMinByte0)
                     && (in_data[15:8] == crfc_pkg::SessByte1)
                     && (in_data[23:16] == crfc_pkg::SessByte2);
    assign read_reply = (in_len >= crfc_pkg::ReadMinLen)
                     && (in_data[15:8] == crfc_pkg::ReadByte1);

    // Latched diagnostic state and receive time.
    logic                       sess_flag_reg, sess_flag_next;
    logic                       read_flag_reg, read_flag_next;
    logic [crfc_pkg::PidW-1:0]  read_pid_reg, read_pid_next;
    logic [crfc_pkg::ValW-1:0]  read_val_reg, read_val_next;
    logic [crfc_pkg::TimeW-1:0] last_rx_reg, last_rx_next;
    logic                       take_read_ok;

    assign take_read_ok = read_flag_reg && (read_pid_reg == in_pid);

    always_comb begin
        sess_flag_next = sess_flag_reg;
        read_flag_next = read_flag_reg;
        read_pid_next  = read_pid_reg;
        read_val_next  = read_val_reg;
        last_rx_next   = last_rx_reg;
        if (accept) begin
            if (is_frame) begin
                last_rx_next = in_now;
                if (diag_hit) begin
                    if (sess_reply) begin
                        sess_flag_next = 1'b1;
                    end else if (read_reply) begin
                        read_flag_next = 1'b1;
                        read_pid_next  = in_data[23:16];
                        read_val_next  = {in_data[31:24], in_data[39:32]};
                    end
                end
            end
            if (is_sess_req || is_take_sess) begin
                sess_flag_next = 1'b0;
            end
            if (is_read_req || (is_take_read && take_read_ok)) begin
                read_flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sess_flag_reg <= 1'b0;
            read_flag_reg <= 1'b0;
            read_pid_reg  <= '0;
            read_val_reg  <= '0;
            last_rx_reg   <= '0;
        end else begin
            sess_flag_reg <= sess_flag_next;
            read_flag_reg <= read_flag_next;
            read_pid_reg  <= read_pid_next;
            read_val_reg  <= read_val_next;
            last_rx_reg   <= last_rx_next;
        end
    end

    // Result parts known at accept time, held until the output register loads.
    logic                      pend_ok_reg, pend_ok_next;
    logic [crfc_pkg::ValW-1:0] pend_val_reg, pend_val_next;
    logic                      pend_slot_reg, pend_slot_next;
    logic                      pend_hit_reg, pend_hit_next;

    always_comb begin
        pend_ok_next   = pend_ok_reg;
        pend_val_next  = pend_val_reg;
        pend_slot_next = pend_slot_reg;
        pend_hit_next  = pend_hit_reg;
        if (accept) begin
            pend_ok_next   = (is_take_sess && sess_flag_reg)
                          || (is_take_read && take_read_ok);
            pend_val_next  = (is_take_read && take_read_ok) ? read_val_reg : '0;
            pend_slot_next = is_get_slot;
            pend_hit_next  = lk_match.hit;
        end
    end

    always_ff @(posedge aclk) begin
        pend_ok_reg   <= pend_ok_next;
        pend_val_reg  <= pend_val_next;
        pend_slot_reg <= pend_slot_next;
        pend_hit_reg  <= pend_hit_next;
    end

    // Output register.
    logic                         out_free, out_load;
    logic                         m_valid_reg, m_valid_next;
    logic [crfc_pkg::MTdataW-1:0] m_data_reg, m_data_next;
    logic                         res_ok;
    crfc_pkg::slot_entry_t        res_entry;

    assign out_free = !m_valid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crfc_pkg::ST_IDLE: begin
                if (accept && (is_take_sess || is_take_read || is_get_slot)) begin
                    state_next = crfc_pkg::ST_RESP;
                end
            end
            crfc_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = crfc_pkg::ST_IDLE;
                end
            end
            default: state_next = crfc_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            crfc_pkg::ST_IDLE: s_tready = 1'b1;
            crfc_pkg::ST_RESP: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crfc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Result assembly from the pending parts and the slot read.
    always_comb begin
        res_ok    = pend_ok_reg;
        res_entry = '0;
        if (pend_slot_reg) begin
            res_ok = pend_hit_reg && slot_rd_valid;
            if (pend_hit_reg) begin
                res_entry = slot_rd_data;
            end
        end
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {3'b000, last_rx_reg, res_entry.stamp, res_entry.len,
                            res_entry.payload, pend_val_reg, res_ok};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks on the block's own control.
    `CRFC_ASSERT_NEXT(a_resp_after_take, aclk, aresetn,
        accept && (is_take_sess || is_take_read || is_get_slot),
        state_reg == crfc_pkg::ST_RESP)
    `CRFC_ASSERT_NEXT(a_load_gives_valid, aclk, aresetn, out_load, m_tvalid)
    `CRFC_ASSERT_NEXT(a_take_sess_clears, aclk, aresetn,
        accept && is_take_sess, !sess_flag_reg)
    `CRFC_ASSERT_NEXT(a_read_req_clears, aclk, aresetn,
        accept && is_read_req, !read_flag_reg)

endmodule

// ===== sim/can_rx_frame_cache_diag_latch_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the CAN receive frame cache with diagnostic latch.
// Depends on crfc_pkg and can_rx_frame_cache_diag_latch; it predicts every result
// and compares it field by field against the result stream.

module can_rx_frame_cache_diag_latch_test;

    // One input transaction, in the order of the tdata packing.
    typedef struct packed {
        crfc_pkg::mode_t mode;
        logic [28:0]     raw_id;
        logic [3:0]      frame_len;
        logic [63:0]     frame_data;
        logic [7:0]      expected_pid;
        logic [10:0]     lookup_id;
        logic [31:0]     now_ms;
    } can_item_t;

    // One result transaction.
    typedef struct packed {
        logic         ok;
        logic [15:0]  pid_value;
        logic [63:0]  slot_data;
        logic [3:0]   slot_len;
        logic [31:0]  slot_time;
        logic [31:0]  last_rx_ms;
    } cache_reply_t;

    localparam int RandomPerPhase = 230;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [crfc_pkg::STdataW-1:0]   s_tdata = '0;
    logic [crfc_pkg::STuserW-1:0]   s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [crfc_pkg::MTdataW-1:0]   m_tdata;
    logic                           cfg_wr_en = 1'b0;
    logic [crfc_pkg::CfgIdxW-1:0]   cfg_index = '0;
    logic [crfc_pkg::IdW-1:0]       cfg_data = '0;

    // Items waiting for the driver, and results waiting for the monitor.
    can_item_t            bus_items[$];
    cache_reply_t         expected_replies[$];
    can_item_t            cur_item = '0;
    logic                 took_item = 1'b0;
    int                   send_gap = 0;
    int                   stall_left = 0;
    bit                   calm = 1'b0;
    int                   queued_count = 0;
    int                   accepted_count = 0;
    int                   replies_checked = 0;
    int                   settings_used = 0;
    int                   err_count = 0;

    // Predicted state of the block.
    logic [10:0]          id_table[crfc_pkg::NumSlots];
    logic [10:0]          diag_id;
    logic                 cache_valid[crfc_pkg::NumSlots];
    logic [3:0]           cache_len[crfc_pkg::NumSlots];
    logic [63:0]          cache_data[crfc_pkg::NumSlots];
    logic [31:0]          cache_stamp[crfc_pkg::NumSlots];
    logic [31:0]          rx_time;
    logic                 session_seen;
    logic                 read_seen;
    logic [7:0]           read_pid_held;
    logic [15:0]          read_value_held;

    // Candidate PIDs so that read replies and take-read requests often agree.
    logic [7:0]           pid_pool[4] = '{8'h0C, 8'h0D, 8'h05, 8'hFF};

    can_rx_frame_cache_diag_latch dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Lowest-numbered slot whose identifier matches, or -1.
    function automatic int slot_of_id(input logic [10:0] id);
        for (int k = 0; k < crfc_pkg::NumSlots; k++) begin
            if (id_table[k] == id) return k;
        end
        return -1;
    endfunction

    // Applies one accepted item to the predicted state; returns 1 when the
    // item yields a result, which is then placed in reply.
    function automatic bit predict_cache_reply(input can_item_t it,
                                               output cache_reply_t reply);
        logic [10:0] id;
        logic [3:0]  cl;
        logic [63:0] keep;
        int          k;
        reply = '0;
        case (it.mode)
            crfc_pkg::MODE_FRAME: begin
                id = it.raw_id[10:0];
                rx_time = it.now_ms;
                k = slot_of_id(id);
                if (k >= 0) begin
                    cl = (it.frame_len > crfc_pkg::MaxLen) ? crfc_pkg::MaxLen
                                                           : it.frame_len;
                    keep = (cl == crfc_pkg::MaxLen) ? '1 : ((64'd1 << (8 * cl)) - 64'd1);
                    cache_valid[k] = 1'b1;
                    cache_len[k] = cl;
                    cache_data[k] = it.frame_data & keep;
                    cache_stamp[k] = it.now_ms;
                end else if (id == diag_id) begin
                    // The session reply is recognized ahead of the read reply.
                    if (it.frame_len >= crfc_pkg::SessMinLen &&
                        it.frame_data[7:0] >= crfc_pkg::SessMinByte0 &&
                        it.frame_data[15:8] == crfc_pkg::SessByte1 &&
                        it.frame_data[23:16] == crfc_pkg::SessByte2) begin
                        session_seen = 1'b1;
                    end else if (it.frame_len >= crfc_pkg::ReadMinLen &&
                                 it.frame_data[15:8] == crfc_pkg::ReadByte1) begin
                        read_pid_held = it.frame_data[23:16];
                        read_value_held = {it.frame_data[31:24], it.frame_data[39:32]};
                        read_seen = 1'b1;
                    end
                end
                return 1'b0;
            end
            crfc_pkg::MODE_SESS_REQ: begin
                session_seen = 1'b0;
                return 1'b0;
            end
            crfc_pkg::MODE_READ_REQ: begin
                read_seen = 1'b0;
                return 1'b0;
            end
            crfc_pkg::MODE_TAKE_SESS: begin
                reply.ok = session_seen;
                session_seen = 1'b0;
            end
            crfc_pkg::MODE_TAKE_READ: begin
                if (read_seen && read_pid_held == it.expected_pid) begin
                    reply.ok = 1'b1;
                    reply.pid_value = read_value_held;
                    read_seen = 1'b0;
                end
            end
            crfc_pkg::MODE_GET_SLOT: begin
                k = slot_of_id(it.lookup_id);
                if (k >= 0) begin
                    reply.ok = cache_valid[k];
                    reply.slot_data = cache_data[k];
                    reply.slot_len = cache_len[k];
                    reply.slot_time = cache_stamp[k];
                end
            end
            default: return 1'b0;
        endcase
        reply.last_rx_ms = rx_time;
        return 1'b1;
    endfunction

    task automatic flag_error(input string what, input logic [63:0] got,
                              input logic [63:0] want);
        $display("ERROR at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Driver: presents the next queued item at the falling edge, with random gaps.
    always @(negedge aclk) begin
        can_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || took_item) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (bus_items.size() != 0) begin
                nxt = bus_items.pop_front();
                cur_item <= nxt;
                s_tdata <= {4'b0, nxt.now_ms, nxt.lookup_id, nxt.expected_pid,
                            nxt.frame_data, nxt.frame_len, nxt.raw_id};
                s_tuser <= nxt.mode;
                s_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls the result stream in random bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 6) == 0) stall_left <= $urandom_range(1, 4);
        end
    end

    // Monitor: checks each result transaction, then predicts from each input one.
    always @(posedge aclk) begin
        cache_reply_t got;
        cache_reply_t want;
        took_item <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got.ok         = m_tdata[0];
            got.pid_value  = m_tdata[16:1];
            got.slot_data  = m_tdata[80:17];
            got.slot_len   = m_tdata[84:81];
            got.slot_time  = m_tdata[116:85];
            got.last_rx_ms = m_tdata[148:117];
            if (expected_replies.size() == 0) begin
                flag_error("unexpected result, ok/pid", got.ok, got.pid_value);
            end else begin
                want = expected_replies.pop_front();
                replies_checked++;
                if (got.ok !== want.ok) flag_error("ok", got.ok, want.ok);
                if (got.pid_value !== want.pid_value)
                    flag_error("pid_value", got.pid_value, want.pid_value);
                if (got.slot_data !== want.slot_data)
                    flag_error("slot_data", got.slot_data, want.slot_data);
                if (got.slot_len !== want.slot_len)
                    flag_error("slot_len", got.slot_len, want.slot_len);
                if (got.slot_time !== want.slot_time)
                    flag_error("slot_time", got.slot_time, want.slot_time);
                if (got.last_rx_ms !== want.last_rx_ms)
                    flag_error("last_rx_ms", got.last_rx_ms, want.last_rx_ms);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            accepted_count++;
            if (predict_cache_reply(cur_item, want)) expected_replies.push_back(want);
        end
    end

    task automatic queue_item(input can_item_t it);
        bus_items.push_back(it);
        queued_count++;
    endtask

    function automatic can_item_t frame_item(input logic [28:0] raw, input logic [3:0] len,
                                             input logic [63:0] data, input logic [31:0] now);
        can_item_t it;
        it.mode = crfc_pkg::MODE_FRAME;
        it.raw_id = raw;
        it.frame_len = len;
        it.frame_data = data;
        it.expected_pid = 8'($urandom);
        it.lookup_id = 11'($urandom);
        it.now_ms = now;
        return it;
    endfunction

    function automatic can_item_t query_item(input crfc_pkg::mode_t mode,
                                             input logic [7:0] pid,
                                             input logic [10:0] lookup);
        can_item_t it;
        it.mode = mode;
        it.raw_id = 29'($urandom);
        it.frame_len = 4'($urandom);
        it.frame_data = {$urandom, $urandom};
        it.expected_pid = pid;
        it.lookup_id = lookup;
        it.now_ms = $urandom;
        return it;
    endfunction

    // Random item aimed mostly at configured identifiers and well-formed replies.
    function automatic can_item_t random_item(ref logic [31:0] clock_ms);
        can_item_t   it;
        int          r;
        int          pick;
        logic [10:0] id;
        logic [63:0] data;
        logic [3:0]  len;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            pick = $urandom_range(0, 9);
            if (pick < crfc_pkg::NumSlots) id = id_table[pick];
            else if (pick < 7) id = diag_id;
            else id = 11'($urandom);
            data = {$urandom, $urandom};
            len = 4'($urandom_range(0, 15));
            if (id == diag_id && $urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    // Session reply, now and then with a too-small first byte.
                    data[7:0] = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 1))
                                                            : 8'($urandom_range(2, 255));
                    data[15:8] = crfc_pkg::SessByte1;
                    data[23:16] = crfc_pkg::SessByte2;
                end else begin
                    data[15:8] = crfc_pkg::ReadByte1;
                    data[23:16] = ($urandom_range(0, 2) != 0) ? pid_pool[$urandom_range(0, 3)]
                                                              : 8'($urandom);
                end
                if ($urandom_range(0, 3) != 0) len = 4'($urandom_range(5, 15));
            end
            if ($urandom_range(0, 4) == 0) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, 50);
            it = frame_item({18'($urandom), id}, len, data, clock_ms);
        end else if (r < 50) begin
            it = query_item(crfc_pkg::MODE_SESS_REQ, 8'($urandom), 11'($urandom));
        end else if (r < 55) begin
            it = query_item(crfc_pkg::MODE_READ_REQ, 8'($urandom), 11'($urandom));
        end else if (r < 65) begin
            it = query_item(crfc_pkg::MODE_TAKE_SESS, 8'($urandom), 11'($urandom));
        end else if (r < 80) begin
            it = query_item(crfc_pkg::MODE_TAKE_READ,
                            ($urandom_range(0, 4) < 3) ? pid_pool[$urandom_range(0, 3)]
                                                       : 8'($urandom),
                            11'($urandom));
        end else begin
            it = query_item(crfc_pkg::MODE_GET_SLOT, 8'($urandom),
                            ($urandom_range(0, 9) < 8) ? id_table[$urandom_range(0, 4)]
                                                       : 11'($urandom));
        end
        return it;
    endfunction

    // Waits until every item is taken and every result has come, then lets
    // the block settle.
    task automatic drain_block();
        while (accepted_count != queued_count) @(negedge aclk);
        while (expected_replies.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_id_reg(input crfc_pkg::cfg_reg_t idx, input logic [10:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == crfc_pkg::REG_DIAG_ID) diag_id = value;
        else id_table[idx] = value;
    endtask

    // Programs all six identifier registers; the block is idle at this point.
    task automatic program_ids(input logic [10:0] s0, input logic [10:0] s1,
                               input logic [10:0] s2, input logic [10:0] s3,
                               input logic [10:0] s4, input logic [10:0] dg);
        write_id_reg(crfc_pkg::REG_RPM_ID, s0);
        write_id_reg(crfc_pkg::REG_SPEED_ID, s1);
        write_id_reg(crfc_pkg::REG_COOLANT_ID, s2);
        write_id_reg(crfc_pkg::REG_GEAR_ID, s3);
        write_id_reg(crfc_pkg::REG_FUEL_ID, s4);
        write_id_reg(crfc_pkg::REG_DIAG_ID, dg);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Run limit, far above the slowest correct run.
    initial begin
        #2000000;
        $display("can_rx_frame_cache_diag_latch_test: done, errors");
        $finish;
    end

    // Stimulus and run control.
    initial begin
        logic [31:0] clock_ms;
        logic [10:0] spare;
        id_table[0] = crfc_pkg::RstRpmId;
        id_table[1] = crfc_pkg::RstSpeedId;
        id_table[2] = crfc_pkg::RstCoolantId;
        id_table[3] = crfc_pkg::RstGearId;
        id_table[4] = crfc_pkg::RstFuelId;
        diag_id = crfc_pkg::RstDiagId;
        for (int k = 0; k < crfc_pkg::NumSlots; k++) begin
            cache_valid[k] = 1'b0;
            cache_len[k] = '0;
            cache_data[k] = '0;
            cache_stamp[k] = '0;
        end
        rx_time = '0;
        session_seen = 1'b0;
        read_seen = 1'b0;
        read_pid_held = '0;
        read_value_held = '0;
        clock_ms = 32'd100;
        settings_used = 1;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the default identifiers.
        queue_item(query_item(crfc_pkg::MODE_GET_SLOT, 8'h00, crfc_pkg::RstRpmId));
        queue_item(frame_item({18'h3FFFF, crfc_pkg::RstRpmId}, 4'd8, '1, 32'hFFFF_FFFF));
        queue_item(frame_item({18'h0, crfc_pkg::RstSpeedId}, 4'd15, '1, 32'h0));
        queue_item(frame_item({18'h2AAAA, crfc_pkg::RstCoolantId}, 4'd0, '1, 32'h1));
        queue_item(frame_item({18'h15555, crfc_pkg::RstGearId}, 4'd3,
                              64'h0123_4567_89AB_CDEF, 32'h2));
        queue_item(frame_item({18'h0, crfc_pkg::RstFuelId}, 4'd7, '1, 32'h3));
        for (int k = 0; k < crfc_pkg::NumSlots; k++)
            queue_item(query_item(crfc_pkg::MODE_GET_SLOT, 8'hFF, id_table[k]));
        // Lookup of an identifier that no slot holds.
        queue_item(query_item(crfc_pkg::MODE_GET_SLOT, 8'h00, 11'h7FF));
        // Session reply latched once, consumed once.
        queue_item(frame_item({18'h0, crfc_pkg::RstDiagId}, 4'd3,
                              64'h0000_0000_0080_5002, 32'd10));
        queue_item(query_item(crfc_pkg::MODE_TAKE_SESS, 8'h00, 11'h0));
        queue_item(query_item(crfc_pkg::MODE_TAKE_SESS, 8'h00, 11'h0));
        // Read reply: wrong PID, right PID, then nothing left.
        queue_item(frame_item({18'h0, crfc_pkg::RstDiagId}, 4'd5,
                              64'h0000_0034_12AB_6103, 32'd20));
        queue_item(query_item(crfc_pkg::MODE_TAKE_READ, 8'hAC, 11'h0));
        queue_item(query_item(crfc_pkg::MODE_TAKE_READ, 8'hAB, 11'h0));
        queue_item(query_item(crfc_pkg::MODE_TAKE_READ, 8'hAB, 11'h0));
        // Session reply whose first byte is too small.
        queue_item(frame_item({18'h0, crfc_pkg::RstDiagId}, 4'd3,
                              64'h0000_0000_0080_5001, 32'd30));
        queue_item(query_item(crfc_pkg::MODE_TAKE_SESS, 8'h00, 11'h0));
        // A sent request clears a latched flag.
        queue_item(frame_item({18'h0, crfc_pkg::RstDiagId}, 4'd8,
                              64'hFFFF_FFFF_FF80_50FF, 32'd40));
        queue_item(query_item(crfc_pkg::MODE_SESS_REQ, 8'h00, 11'h0));
        queue_item(query_item(crfc_pkg::MODE_TAKE_SESS, 8'h00, 11'h0));
        queue_item(frame_item({18'h0, crfc_pkg::RstDiagId}, 4'd15,
                              64'h0000_00FF_FF55_61FF, 32'd50));
        queue_item(query_item(crfc_pkg::MODE_READ_REQ, 8'h55, 11'h0));
        queue_item(query_item(crfc_pkg::MODE_TAKE_READ, 8'h55, 11'h0));
        for (int n = 0; n < RandomPerPhase; n++) queue_item(random_item(clock_ms));
        drain_block();

        // All identifiers zero: every match lands in slot 0.
        program_ids(11'h000, 11'h000, 11'h000, 11'h000, 11'h000, 11'h000);
        for (int n = 0; n < RandomPerPhase; n++) queue_item(random_item(clock_ms));
        drain_block();

        // All identifiers at the top of their range.
        program_ids(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
        for (int n = 0; n < RandomPerPhase; n++) queue_item(random_item(clock_ms));
        drain_block();

        // Random identifiers.
        program_ids(11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom),
                    11'($urandom), 11'($urandom));
        for (int n = 0; n < RandomPerPhase; n++) queue_item(random_item(clock_ms));
        drain_block();

        // Mixed extremes with a duplicate pair, run back to back without idling.
        spare = 11'($urandom);
        program_ids(11'h7FF, 11'h000, spare, spare, 11'($urandom), 11'($urandom));
        calm = 1'b1;
        for (int n = 0; n < RandomPerPhase; n++) queue_item(random_item(clock_ms));
        drain_block();
        repeat (8) @(negedge aclk);

        if (expected_replies.size() != 0)
            flag_error("results never delivered", expected_replies.size(), 0);
        $display("Covered %0d input transactions and %0d checked results",
                 accepted_count, replies_checked);
        $display("over %0d identifier settings.", settings_used);
        if (err_count == 0) begin
            $display("can_rx_frame_cache_diag_latch_test: done, clean");
        end else begin
            $display("can_rx_frame_cache_diag_latch_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/crfc_pkg.sv
rtl/core/crfc_id_match.sv
rtl/core/crfc_slot_mem.sv
rtl/core/can_rx_frame_cache_diag_latch.sv
sim/can_rx_frame_cache_diag_latch_test.sv
